[sv/divider_64bit_signed_unsigned_macros.svh]
// Assertion macros for the divider checker
`ifndef DIVIDER_64BIT_SIGNED_UNSIGNED_MACROS_SVH
`define DIVIDER_64BIT_SIGNED_UNSIGNED_MACROS_SVH

// same-cycle implication
`define DIV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("divider check failed: same-cycle implication");

// next-cycle implication
`define DIV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("divider check failed: next-cycle implication");

`endif

[sv/div64_pkg.sv]
// Shared types and constants for the 64-bit divider
`timescale 1ns / 1ps
package div64_pkg;
	localparam int unsigned FIELD_W = 64;
	localparam int unsigned FUNC_W  = 2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SQUO = 2'd0,
		FUNC_SREM = 2'd1,
		FUNC_UQUO = 2'd2,
		FUNC_UREM = 2'd3
	} div64_func_t;

	// status of the shift-subtract unit
	typedef struct packed {
		logic busy;
		logic last;
	} div64_stat_t;
endpackage

[sv/div64_if.sv]
// Request and response channel interfaces of the divider
`timescale 1ns / 1ps
interface div64_req_if import div64_pkg::*;;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [FIELD_W-1:0] dividend;
	logic [FIELD_W-1:0] divisor;

	modport source (output valid, output func, output dividend, output divisor, input ready);
	modport sink (input valid, input func, input dividend, input divisor, output ready);
endinterface

interface div64_rsp_if import div64_pkg::*;;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

[sv/div64_unit.sv]
// Restoring shift-subtract unit: one quotient bit per cycle
`timescale 1ns / 1ps
module div64_unit import div64_pkg::*; #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] num,
	input  logic [DATA_WIDTH-1:0] den,
	output div64_stat_t           stat,
	output logic [DATA_WIDTH-1:0] quo,
	output logic [DATA_WIDTH-1:0] rem
);
	localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] quo_q;   // dividend bits shift out the top, quotient bits in the bottom
	logic [DATA_WIDTH-1:0] den_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;

	logic [DATA_WIDTH:0]   part;
	logic [DATA_WIDTH:0]   diff;
	logic                  ge;
	logic [DATA_WIDTH-1:0] rem_next;

	// partial remainder keeps its carry bit, so a divisor with the top bit set still works
	always_comb begin
		part     = {rem_q, quo_q[DATA_WIDTH-1]};
		diff     = part - {1'b0, den_q};
		ge       = part >= {1'b0, den_q};
		rem_next = ge ? diff[DATA_WIDTH-1:0] : part[DATA_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DATA_WIDTH - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DATA_WIDTH-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.last = busy_q && (cnt_q == '0);
	assign quo       = quo_q;
	assign rem       = rem_q;
endmodule

[sv/divider_64bit_signed_unsigned.sv]
// Top level of the signed/unsigned iterative divider
`timescale 1ns / 1ps
// Iterative integer divider. Each request beat carries func (signed quotient, signed remainder,
// unsigned quotient, unsigned remainder) and two operands; only the low DATA_WIDTH bits are
// used and the result beat is zero above DATA_WIDTH. Quotients truncate toward zero, signed
// remainders take the dividend's sign, and the most negative value over -1 wraps to itself.
// A zero divisor gives an all-ones magnitude quotient (so -1, or +1 for a negative dividend,
// when signed) and returns the dividend as remainder; there is no error flag. One item is in
// flight at a time: ready drops after the accepting edge and returns when the result is loaded
// into the output register, so no new item is taken until the last one has passed through the
// single shift-subtract unit, which retires one quotient bit per cycle, and the sign fix-up
// state. A result still waiting on the response side holds the fix-up state until it is taken.
module divider_64bit_signed_unsigned import div64_pkg::*; #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	div64_req_if.sink   req,
	div64_rsp_if.source rsp
);
	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_FIX
	} state_t;

	state_t                state_q;
	logic                  sel_rem_q;
	logic                  neg_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] res_q;

	div64_func_t           func;
	logic                  is_signed;
	logic                  sel_rem;
	logic [DATA_WIDTH-1:0] op_a;
	logic [DATA_WIDTH-1:0] op_b;
	logic                  neg_a;
	logic                  neg_b;
	logic [DATA_WIDTH-1:0] mag_a;
	logic [DATA_WIDTH-1:0] mag_b;
	logic                  accept;
	logic                  load_rsp;
	logic [DATA_WIDTH-1:0] pick;
	logic [DATA_WIDTH-1:0] fixed;

	div64_stat_t           stat;
	logic [DATA_WIDTH-1:0] quo;
	logic [DATA_WIDTH-1:0] rem;

	always_comb begin
		func      = div64_func_t'(req.func);
		is_signed = (func == FUNC_SQUO) || (func == FUNC_SREM);
		sel_rem   = (func == FUNC_SREM) || (func == FUNC_UREM);
		op_a      = req.dividend[DATA_WIDTH-1:0];
		op_b      = req.divisor[DATA_WIDTH-1:0];
		neg_a     = is_signed && op_a[DATA_WIDTH-1];
		neg_b     = is_signed && op_b[DATA_WIDTH-1];
		mag_a     = neg_a ? ('0 - op_a) : op_a;
		mag_b     = neg_b ? ('0 - op_b) : op_b;
		accept    = req.valid && req.ready;
		load_rsp  = (state_q == S_FIX) && (!out_valid_q || rsp.ready);
		pick      = sel_rem_q ? rem : quo;
		fixed     = neg_q ? ('0 - pick) : pick;
	end

	div64_unit #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_unit (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.num   (mag_a),
		.den   (mag_b),
		.stat  (stat),
		.quo   (quo),
		.rem   (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_rem_q   <= 1'b0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (rsp.valid && rsp.ready && !load_rsp) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						sel_rem_q <= sel_rem;
						// remainder follows the dividend's sign, quotient the sign product
						neg_q     <= sel_rem ? neg_a : (neg_a ^ neg_b);
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					if (stat.last) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					if (load_rsp) begin
						res_q       <= fixed;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready  = (state_q == S_IDLE) && !stat.busy;
	assign rsp.valid  = out_valid_q;
	assign rsp.result = FIELD_W'(res_q);
endmodule

[sv/div64_chk.sv]
// Port-level checker for the divider and its bind
`timescale 1ns / 1ps
`include "divider_64bit_signed_unsigned_macros.svh"
module div64_chk import div64_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [FIELD_W-1:0] rsp_result
);
	// a stalled result beat keeps its value
	`DIV_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result))
	// one item at a time: no new request right after one is taken
	`DIV_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
	// a new result only appears at the end of a division, never while idle
	`DIV_ASSERT_IMP(a_result_from_work, clk, arst_n, $rose(rsp_valid), $past(!req_ready))
endmodule

bind divider_64bit_signed_unsigned div64_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_result(rsp.result)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for the 64-bit signed/unsigned divider
`timescale 1ns / 1ps
module tb_top import div64_pkg::*;;
	localparam int unsigned W        = FIELD_W;
	localparam int unsigned LIMIT    = 600000;
	localparam int unsigned N_RANDOM = 950;
	localparam int unsigned HOLD_LEN = 400;
	localparam logic [W-1:0] ALL_ONES = '1;
	localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

	logic clk;
	logic arst_n;
	int unsigned cycle_cnt;
	int unsigned sent_cnt;
	int unsigned rx_taken;

	div64_req_if req_ch ();
	div64_rsp_if rsp_ch ();

	divider_64bit_signed_unsigned DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	class quotient_board;
		logic [W-1:0] owed_results[$];
		int unsigned mismatch_cnt;

		function new();
			mismatch_cnt = 0;
		endfunction

		// signed ops work on magnitudes, sign fixed afterwards with wrap
		function logic [W-1:0] predict_division(div64_func_t f, logic [W-1:0] a,
				logic [W-1:0] b);
			logic is_signed;
			logic neg_a;
			logic neg_b;
			logic [W-1:0] mag_a;
			logic [W-1:0] mag_b;
			logic [W-1:0] quo;
			logic [W-1:0] rem;
			is_signed = (f == FUNC_SQUO) || (f == FUNC_SREM);
			neg_a = is_signed && a[W-1];
			neg_b = is_signed && b[W-1];
			mag_a = neg_a ? ({W{1'b0}} - a) : a;
			mag_b = neg_b ? ({W{1'b0}} - b) : b;
			if (mag_b == '0) begin
				quo = ALL_ONES;
				rem = mag_a;
			end else begin
				quo = mag_a / mag_b;
				rem = mag_a % mag_b;
			end
			case (f)
				FUNC_SQUO: return (neg_a != neg_b) ? ({W{1'b0}} - quo) : quo;
				FUNC_SREM: return neg_a ? ({W{1'b0}} - rem) : rem;
				FUNC_UQUO: return quo;
				default:   return rem;
			endcase
		endfunction

		function void log_request(div64_func_t f, logic [W-1:0] a, logic [W-1:0] b);
			owed_results.push_back(predict_division(f, a, b));
		endfunction

		function void check_result(logic [W-1:0] actual);
			logic [W-1:0] want;
			if (owed_results.size() == 0) begin
				$error("result: none expected, actual %h", actual);
				mismatch_cnt++;
				return;
			end
			want = owed_results.pop_front();
			if (actual !== want) begin
				$error("result: expected %h, actual %h", want, actual);
				mismatch_cnt++;
			end
		endfunction

		function int unsigned pending();
			return owed_results.size();
		endfunction
	endclass

	quotient_board board = new();

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// beat monitors
	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready)
			board.log_request(div64_func_t'(req_ch.func), req_ch.dividend, req_ch.divisor);
		if (rsp_ch.valid && rsp_ch.ready)
			board.check_result(rsp_ch.result);
	end

	// response side: random stalls, one long hold-off, one stretch always ready
	initial begin
		int unsigned hold_left;
		bit held;
		hold_left = 0;
		held = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				rx_taken++;
			if (!held && rx_taken == 40) begin
				held = 1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rx_taken >= 300 && rx_taken < 500) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= 37);
			end
		end
	end

	function automatic logic [W-1:0] pick_operand();
		int unsigned sel;
		logic [W-1:0] v;
		sel = $urandom_range(0, 99);
		v = {$urandom(), $urandom()};
		if (sel < 35)
			return v;
		else if (sel < 50)
			return W'($urandom_range(0, 255));
		else if (sel < 75)
			return v >> $urandom_range(0, W - 1);
		else if (sel < 85)
			return {W{1'b0}} - W'($urandom_range(1, 255));
		case ($urandom_range(0, 4))
			0: return '0;
			1: return W'(1);
			2: return ALL_ONES;
			3: return MOST_NEG;
			default: return MOST_POS;
		endcase
	endfunction

	task automatic send_beat(div64_func_t f, logic [W-1:0] a, logic [W-1:0] b);
		int unsigned gap;
		gap = 0;
		if (sent_cnt < 320 || sent_cnt >= 520)
			while ($urandom_range(0, 99) < 37)
				gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.func     <= f;
		req_ch.dividend <= a;
		req_ch.divisor  <= b;
		do @(posedge clk); while (!req_ch.ready);
		sent_cnt++;
	endtask

	initial begin
		div64_func_t f;
		logic [W-1:0] a;
		logic [W-1:0] b;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_SQUO;
		req_ch.dividend = '0;
		req_ch.divisor = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: sign mixes, most negative over -1, zero divisors, extremes
		for (int k = 0; k < 4; k++) begin
			f = div64_func_t'(k);
			send_beat(f, {W{1'b0}} - W'(100), W'(7));
			send_beat(f, W'(100), {W{1'b0}} - W'(7));
			send_beat(f, MOST_NEG, ALL_ONES);
			send_beat(f, {W{1'b0}} - W'(5), '0);
			send_beat(f, MOST_POS, '0);
			send_beat(f, ALL_ONES, MOST_POS);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			f = div64_func_t'($urandom_range(0, 3));
			a = pick_operand();
			b = pick_operand();
			send_beat(f, a, b);
		end
		req_ch.valid <= 1'b0;
		// let the monitor log the last accepted beat first
		@(posedge clk);

		while (board.pending() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (board.mismatch_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

[files.f]
+incdir+sv
sv/div64_pkg.sv
sv/div64_if.sv
sv/div64_unit.sv
sv/divider_64bit_signed_unsigned.sv
sv/div64_chk.sv
tb/sv/tb_top.sv
